// File: rtl/core/lhel_pkg.sv
// ----------------------------------------------------------------------------
// lhel_pkg
// Shared types and constants for the link header EtherType locator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lhel_pkg;

    localparam int POS_W = 17;
    localparam int RT_W  = 16;
    localparam int ET_W  = 16;
    localparam int ST_W  = 3;
    localparam int LT_W  = 2;

    // Link types held in the configuration register.
    localparam logic [LT_W-1:0] LT_ETHERNET = 2'd0;
    localparam logic [LT_W-1:0] LT_COOKED   = 2'd1;
    localparam logic [LT_W-1:0] LT_RAW_WLAN = 2'd2;
    localparam logic [LT_W-1:0] LT_RADIOTAP = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_IP       = 3'd0;
    localparam logic [ST_W-1:0] ST_VLAN     = 3'd1;
    localparam logic [ST_W-1:0] ST_OTHER    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_SHORT    = 3'd4;

    localparam logic [ET_W-1:0] ET_IPV4 = 16'h0800;
    localparam logic [ET_W-1:0] ET_IPV6 = 16'h86DD;
    localparam logic [ET_W-1:0] ET_VLAN = 16'h8100;

    localparam logic [23:0]      SNAP_HDR     = 24'hAAAA03;
    localparam logic [POS_W-1:0] OFF_ETHERNET = 17'd12;
    localparam logic [POS_W-1:0] OFF_COOKED   = 17'd14;
    localparam logic [POS_W:0]   SEARCH_FIRST = 18'd26;
    localparam logic [POS_W:0]   SEARCH_LAST  = 18'd38;

    typedef enum logic [6:0] {
        PH_START    = 7'b0000001,
        PH_RADIOTAP = 7'b0000010,
        PH_WAIT_FC  = 7'b0000100,
        PH_SEARCH   = 7'b0001000,
        PH_READ     = 7'b0010000,
        PH_FOUND    = 7'b0100000,
        PH_NOTFOUND = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] ethertype_offset;
        logic [ET_W-1:0]  ethertype_value;
        logic [ST_W-1:0]  status;
    } t_result;

endpackage

// File: rtl/core/lhel_if.sv
// ----------------------------------------------------------------------------
// lhel_if
// Valid/ready channels of the EtherType locator: frame bytes, results and
// the link type register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lhel_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface lhel_result_if;
    logic                          valid;
    logic                          ready;
    logic [lhel_pkg::POS_W-1:0]    ethertype_offset;
    logic [lhel_pkg::ET_W-1:0]     ethertype_value;
    logic [lhel_pkg::ST_W-1:0]     status;
    modport source (output valid, ethertype_offset, ethertype_value, status, input ready);
    modport sink   (input valid, ethertype_offset, ethertype_value, status, output ready);
endinterface

interface lhel_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lhel_pkg::LT_W-1:0]  link_type;
    modport source (output valid, link_type, input ready);
    modport sink   (input valid, link_type, output ready);
endinterface

// File: rtl/core/lhel_in_reg.sv
// ----------------------------------------------------------------------------
// lhel_in_reg
// Input register ahead of the parser: one byte per cycle while it takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhel_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lhel_frame_if.sink         i_frame,
    input  logic               i_take,
    output logic               o_valid,
    output lhel_pkg::t_item    o_item
);

    logic            r_valid;
    lhel_pkg::t_item r_item;
    logic            w_load;

    assign i_frame.ready = !r_valid || i_take;
    assign w_load        = i_frame.valid && i_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.frame_byte <= i_frame.frame_byte;
            r_item.frame_end  <= i_frame.frame_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/lhel_parser.sv
// ----------------------------------------------------------------------------
// lhel_parser
// Per-frame parse state and the combinational step that consumes one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhel_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lhel_pkg::LT_W-1:0]      i_link_type,
    input  logic                           i_valid,
    input  lhel_pkg::t_item                i_item,
    input  logic                           i_out_free,
    output logic                           o_take,
    output logic                           o_res_valid,
    output lhel_pkg::t_result              o_res
);

    localparam int PW = lhel_pkg::POS_W;

    lhel_pkg::t_phase          r_phase, n_phase;
    logic [PW-1:0]             r_pos, n_pos;
    logic [lhel_pkg::RT_W-1:0] r_rtlen, n_rtlen;
    logic [15:0]               r_recent, n_recent;
    logic [PW-1:0]             r_found, n_found;
    logic [lhel_pkg::ET_W-1:0] r_type, n_type;
    logic [7:0]                w_b;
    logic [1:0]                w_ftype;
    logic [3:0]                w_fsub;
    logic [PW:0]               w_pos_x;
    logic [PW:0]               w_rt_x;
    logic [PW:0]               w_found_x;

    // A byte that closes a frame may only move on when the result register
    // can take the result.
    assign o_take  = i_valid && (!i_item.frame_end || i_out_free);
    assign w_b     = i_item.frame_byte;
    assign w_ftype = w_b[3:2];
    assign w_fsub  = w_b[7:4];

    always_comb begin
        n_phase   = r_phase;
        n_rtlen   = r_rtlen;
        n_found   = r_found;
        n_type    = r_type;
        n_recent  = {r_recent[7:0], w_b};
        w_pos_x   = {1'b0, r_pos};
        w_rt_x    = '0;
        w_found_x = '0;

        if (n_phase == lhel_pkg::PH_START) begin
            unique case (i_link_type)
                lhel_pkg::LT_ETHERNET: begin
                    n_found = lhel_pkg::OFF_ETHERNET;
                    n_phase = lhel_pkg::PH_READ;
                end
                lhel_pkg::LT_COOKED: begin
                    n_found = lhel_pkg::OFF_COOKED;
                    n_phase = lhel_pkg::PH_READ;
                end
                lhel_pkg::LT_RAW_WLAN: begin
                    n_rtlen = '0;
                    n_phase = lhel_pkg::PH_WAIT_FC;
                end
                default: begin
                    n_phase = lhel_pkg::PH_RADIOTAP;
                end
            endcase
        end

        // Radiotap length is little-endian at bytes two and three.
        if (n_phase == lhel_pkg::PH_RADIOTAP) begin
            if (r_pos == PW'(2)) begin
                n_rtlen = {8'd0, w_b};
            end else if (r_pos == PW'(3)) begin
                n_rtlen = {w_b, n_rtlen[7:0]};
                n_phase = (n_rtlen < 16'd4) ? lhel_pkg::PH_NOTFOUND
                                            : lhel_pkg::PH_WAIT_FC;
            end
        end

        w_rt_x    = {{(PW + 1 - lhel_pkg::RT_W){1'b0}}, n_rtlen};
        w_found_x = {1'b0, n_found};

        if (n_phase == lhel_pkg::PH_WAIT_FC && w_pos_x == w_rt_x) begin
            // Only data frames carry an LLC/SNAP header worth searching.
            if (w_ftype == 2'd2 && (w_fsub < 4'd4 || (w_fsub >= 4'd8 && w_fsub < 4'd12))) begin
                n_phase = lhel_pkg::PH_SEARCH;
            end else begin
                n_phase = lhel_pkg::PH_NOTFOUND;
            end
        end else if (n_phase == lhel_pkg::PH_SEARCH) begin
            if (w_pos_x >= w_rt_x + lhel_pkg::SEARCH_FIRST
                    && {r_recent, w_b} == lhel_pkg::SNAP_HDR) begin
                n_found = r_pos + PW'(4);
                n_phase = lhel_pkg::PH_READ;
            end else if (w_pos_x >= w_rt_x + lhel_pkg::SEARCH_LAST) begin
                n_phase = lhel_pkg::PH_NOTFOUND;
            end
        end else if (n_phase == lhel_pkg::PH_READ) begin
            if (w_pos_x == w_found_x) begin
                n_type = {w_b, 8'd0};
            end else if (w_pos_x == w_found_x + (PW + 1)'(1)) begin
                n_type  = {n_type[15:8], w_b};
                n_phase = lhel_pkg::PH_FOUND;
            end
        end

        n_pos = (r_pos == '1) ? r_pos : r_pos + PW'(1);
    end

    always_comb begin
        o_res.ethertype_offset = '0;
        o_res.ethertype_value  = '0;
        o_res.status           = lhel_pkg::ST_SHORT;
        if (n_phase == lhel_pkg::PH_FOUND) begin
            o_res.ethertype_value  = n_type;
            o_res.ethertype_offset = n_found;
            if (n_type == lhel_pkg::ET_IPV4 || n_type == lhel_pkg::ET_IPV6) begin
                o_res.status = lhel_pkg::ST_IP;
            end else if (n_type == lhel_pkg::ET_VLAN) begin
                o_res.status           = lhel_pkg::ST_VLAN;
                o_res.ethertype_offset = n_found + PW'(4);
            end else begin
                o_res.status = lhel_pkg::ST_OTHER;
            end
        end else if (n_phase == lhel_pkg::PH_NOTFOUND) begin
            o_res.status = lhel_pkg::ST_NOTFOUND;
        end
    end

    assign o_res_valid = o_take && i_item.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lhel_pkg::PH_START;
            r_pos    <= '0;
            r_rtlen  <= '0;
            r_recent <= '0;
            r_found  <= '0;
            r_type   <= '0;
        end else if (o_take) begin
            if (i_item.frame_end) begin
                r_phase  <= lhel_pkg::PH_START;
                r_pos    <= '0;
                r_rtlen  <= '0;
                r_recent <= '0;
                r_found  <= '0;
                r_type   <= '0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_rtlen  <= n_rtlen;
                r_recent <= n_recent;
                r_found  <= n_found;
                r_type   <= n_type;
            end
        end
    end

endmodule

// File: rtl/core/lhel_out_reg.sv
// ----------------------------------------------------------------------------
// lhel_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhel_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lhel_pkg::t_result  i_res,
    output logic               o_free,
    lhel_result_if.source      o_result
);

    logic              r_valid;
    lhel_pkg::t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.ethertype_offset = r_res.ethertype_offset;
    assign o_result.ethertype_value  = r_res.ethertype_value;
    assign o_result.status           = r_res.status;

endmodule

// File: rtl/core/link_header_ethertype_locator.sv
// ----------------------------------------------------------------------------
// link_header_ethertype_locator
// Locates the EtherType of a captured frame streamed one byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes one frame byte per cycle and, on the byte marked as the
// frame's last, gives one result: the byte offset of the EtherType, its value
// and a status (IPv4 or IPv6, VLAN skipped, other EtherType, not found, or
// frame too short). Ethernet frames carry the EtherType at offset 12 and
// Linux cooked captures at offset 14; for 802.11 the optional radiotap header
// is skipped by its little-endian length, only data frames are searched, and
// an LLC/SNAP header is looked for at MAC positions 24 to 36. A VLAN EtherType
// adds 4 to the reported offset. The link type register is sampled at each
// frame's first byte, so a write made between frames applies to the next one.
// Throughput is one byte per cycle without a gap, except while a frame's last
// byte is held back as below. A frame's last byte is accepted into the input
// register, and the parse step then loads the result into the result register
// that drives the output. The parse state advances once per byte, and this
// combinational step is what sets the rate. The result register lets the next
// frame's bytes flow in while a result waits to be taken; only a frame's last
// byte is held back when the previous result is still waiting.

module link_header_ethertype_locator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lhel_cfg_if.sink      i_cfg,
    lhel_frame_if.sink    i_frame,
    lhel_result_if.source o_result
);

    logic [lhel_pkg::LT_W-1:0] r_link_type;
    logic                      w_item_valid;
    lhel_pkg::t_item           w_item;
    logic                      w_take;
    logic                      w_out_free;
    logic                      w_res_valid;
    lhel_pkg::t_result         w_res;

    // The link type register is always writable.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type <= lhel_pkg::LT_ETHERNET;
        end else if (i_cfg.valid) begin
            r_link_type <= i_cfg.link_type;
        end
    end

    lhel_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    lhel_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_link_type (r_link_type),
        .i_valid     (w_item_valid),
        .i_item      (w_item),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lhel_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

endmodule

// File: rtl/core/lhel_checker.sv
// ----------------------------------------------------------------------------
// lhel_checker
// Port-level checks on the results of the EtherType locator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhel_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic [lhel_pkg::POS_W-1:0]   i_offset,
    input logic [lhel_pkg::ET_W-1:0]    i_ethertype_value,
    input logic [lhel_pkg::ST_W-1:0]    i_status
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // A failed parse reports zero offset and zero EtherType.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == lhel_pkg::ST_NOTFOUND || i_status == lhel_pkg::ST_SHORT)
        |-> i_offset == '0 && i_ethertype_value == '0)
        else $error("failed parse carries a value");

    // The IP status only goes with an IPv4 or IPv6 EtherType.
    a_ip_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == lhel_pkg::ST_IP
        |-> i_ethertype_value == lhel_pkg::ET_IPV4
            || i_ethertype_value == lhel_pkg::ET_IPV6)
        else $error("IP status with other EtherType");

    // A skipped VLAN tag shows its own EtherType and an offset past the tag.
    a_vlan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == lhel_pkg::ST_VLAN
        |-> i_ethertype_value == lhel_pkg::ET_VLAN && i_offset >= 17'd16)
        else $error("VLAN result inconsistent");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status <= lhel_pkg::ST_SHORT)
        else $error("undefined status code");

endmodule

bind link_header_ethertype_locator lhel_checker u_lhel_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_result.valid),
    .i_offset          (o_result.ethertype_offset),
    .i_ethertype_value (o_result.ethertype_value),
    .i_status          (o_result.status)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link header EtherType locator. Frames for all
// four link types are streamed byte by byte with random gaps and result-side
// stalls, and every result is checked against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // Clock, reset and the three channels of the block.
    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    lhel_cfg_if    cfg_if ();
    lhel_frame_if  frame_if ();
    lhel_result_if res_if ();

    link_header_ethertype_locator u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_if.sink),
        .i_frame  (frame_if.sink),
        .o_result (res_if.source)
    );

    // ------------------------------------------------------------------------
    // Parser model. It mirrors the per-frame state of the block and is stepped
    // once for every byte that the block accepts. The link type copy is only
    // changed while the block is idle, so it is always the one that the next
    // frame's first byte will see.
    // ------------------------------------------------------------------------
    logic [lhel_pkg::LT_W-1:0]  cur_link;
    logic [lhel_pkg::POS_W-1:0] fr_pos;
    logic [lhel_pkg::POS_W-1:0] fr_found;
    logic [lhel_pkg::RT_W-1:0]  fr_rt_len;
    logic [23:0]                fr_recent;
    logic [lhel_pkg::ET_W-1:0]  fr_type;
    lhel_pkg::t_phase           fr_phase;

    // Expected results, oldest first, and the bytes still waiting to be sent.
    lhel_pkg::t_result expected_results[$];
    lhel_pkg::t_item   pending_bytes[$];
    logic [7:0]        fbuf[$];

    int  bytes_queued = 0;
    int  bytes_accepted = 0;
    int  frames_queued = 0;
    int  mismatches = 0;
    int  status_seen[5];
    int  link_writes[4];
    bit  no_idle = 1'b0;

    function automatic void clear_frame_state();
        fr_pos    = '0;
        fr_found  = '0;
        fr_rt_len = '0;
        fr_recent = '0;
        fr_type   = '0;
        fr_phase  = lhel_pkg::PH_START;
    endfunction

    // Steps the model by one byte. Returns 1 when the byte closes a frame, with
    // the result that the block must then give.
    function automatic bit locate_step(input logic [7:0] b, input logic eof,
                                       output lhel_pkg::t_result res);
        logic [lhel_pkg::POS_W-1:0] p;
        logic [1:0]                 ftype;
        logic [3:0]                 fsub;
        p = fr_pos;
        fr_recent = {fr_recent[15:0], b};

        // The link type is looked at only on a frame's first byte.
        if (fr_phase == lhel_pkg::PH_START) begin
            case (cur_link)
                lhel_pkg::LT_ETHERNET: begin
                    fr_found = lhel_pkg::OFF_ETHERNET;
                    fr_phase = lhel_pkg::PH_READ;
                end
                lhel_pkg::LT_COOKED: begin
                    fr_found = lhel_pkg::OFF_COOKED;
                    fr_phase = lhel_pkg::PH_READ;
                end
                lhel_pkg::LT_RAW_WLAN: begin
                    fr_rt_len = '0;
                    fr_phase  = lhel_pkg::PH_WAIT_FC;
                end
                default: fr_phase = lhel_pkg::PH_RADIOTAP;
            endcase
        end

        // Radiotap length is little-endian at bytes 2 and 3; a length below 4
        // would put the frame control byte inside the length field itself.
        if (fr_phase == lhel_pkg::PH_RADIOTAP) begin
            if (p == 2) begin
                fr_rt_len = {8'h00, b};
            end else if (p == 3) begin
                fr_rt_len = {b, fr_rt_len[7:0]};
                fr_phase  = (fr_rt_len < 4) ? lhel_pkg::PH_NOTFOUND
                                            : lhel_pkg::PH_WAIT_FC;
            end
        end

        if (fr_phase == lhel_pkg::PH_WAIT_FC && p == fr_rt_len) begin
            // Only data frames with subtypes 0..3 or 8..11 carry an LLC header.
            ftype = b[3:2];
            fsub  = b[7:4];
            if (ftype == 2'd2 && (fsub < 4 || (fsub >= 8 && fsub < 12))) begin
                fr_phase = lhel_pkg::PH_SEARCH;
            end else begin
                fr_phase = lhel_pkg::PH_NOTFOUND;
            end
        end else if (fr_phase == lhel_pkg::PH_SEARCH) begin
            // The SNAP header must end between MAC positions 26 and 38.
            if ({1'b0, p} >= fr_rt_len + lhel_pkg::SEARCH_FIRST
                    && fr_recent == lhel_pkg::SNAP_HDR) begin
                fr_found = p + 17'd4;
                fr_phase = lhel_pkg::PH_READ;
            end else if ({1'b0, p} >= fr_rt_len + lhel_pkg::SEARCH_LAST) begin
                fr_phase = lhel_pkg::PH_NOTFOUND;
            end
        end else if (fr_phase == lhel_pkg::PH_READ) begin
            if (p == fr_found) begin
                fr_type = {b, 8'h00};
            end else if (p == fr_found + 1'b1) begin
                fr_type[7:0] = b;
                fr_phase = lhel_pkg::PH_FOUND;
            end
        end

        if (!eof) begin
            // The position counter sticks at its maximum on very long frames.
            if (fr_pos != '1) begin
                fr_pos = fr_pos + 1'b1;
            end
            return 1'b0;
        end

        res.ethertype_offset = '0;
        res.ethertype_value  = '0;
        res.status           = lhel_pkg::ST_SHORT;
        if (fr_phase == lhel_pkg::PH_FOUND) begin
            res.ethertype_value  = fr_type;
            res.ethertype_offset = fr_found;
            if (fr_type == lhel_pkg::ET_IPV4 || fr_type == lhel_pkg::ET_IPV6) begin
                res.status = lhel_pkg::ST_IP;
            end else if (fr_type == lhel_pkg::ET_VLAN) begin
                res.status = lhel_pkg::ST_VLAN;
                res.ethertype_offset = fr_found + 17'd4;
            end else begin
                res.status = lhel_pkg::ST_OTHER;
            end
        end else if (fr_phase == lhel_pkg::PH_NOTFOUND) begin
            res.status = lhel_pkg::ST_NOTFOUND;
        end
        clear_frame_state();
        return 1'b1;
    endfunction

    // Idle length: mostly none, sometimes short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver. An item is taken at each edge where valid and ready are both
    // high; the model is stepped with exactly that item before the next one is
    // put on the channel.
    // ------------------------------------------------------------------------
    int unsigned byte_gap;

    always @(posedge clk) begin
        lhel_pkg::t_item   nxt;
        lhel_pkg::t_result res;
        if (!rst_n) begin
            frame_if.valid <= 1'b0;
            byte_gap <= 0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                bytes_accepted++;
                if (locate_step(frame_if.frame_byte, frame_if.frame_end, res)) begin
                    expected_results.push_back(res);
                end
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (byte_gap != 0) begin
                    byte_gap <= byte_gap - 1;
                    frame_if.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    frame_if.valid      <= 1'b1;
                    frame_if.frame_byte <= nxt.frame_byte;
                    frame_if.frame_end  <= nxt.frame_end;
                    byte_gap <= idle_len();
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random back-pressure. Each accepted result is held
    // against the oldest expectation, field by field.
    // ------------------------------------------------------------------------
    int unsigned res_stall;

    always @(posedge clk) begin
        lhel_pkg::t_result got;
        lhel_pkg::t_result want;
        int unsigned       n;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            res_stall <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.ethertype_offset = res_if.ethertype_offset;
                got.ethertype_value  = res_if.ethertype_value;
                got.status           = res_if.status;
                if (got.status <= lhel_pkg::ST_SHORT) begin
                    status_seen[got.status]++;
                end
                if (expected_results.size() == 0) begin
                    $error("unexpected result: offset %0d, ethertype_value %h, status %0d",
                           got.ethertype_offset, got.ethertype_value, got.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.ethertype_offset !== want.ethertype_offset) begin
                        $error("ethertype_offset: expected %0d, got %0d",
                               want.ethertype_offset, got.ethertype_offset);
                        mismatches++;
                    end
                    if (got.ethertype_value !== want.ethertype_value) begin
                        $error("ethertype_value: expected %h, got %h",
                               want.ethertype_value, got.ethertype_value);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (res_stall != 0) begin
                res_stall <= res_stall - 1;
                res_if.ready <= 1'b0;
            end else begin
                n = idle_len();
                res_if.ready <= (n == 0);
                if (n != 0) begin
                    res_stall <= n - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Frame builders. Bytes are gathered in fbuf and handed to the driver as
    // one frame, the last byte carrying frame_end.
    // ------------------------------------------------------------------------

    // Filler leans towards 0xaa so that partial SNAP patterns turn up often.
    function automatic void put_fill(input int n);
        repeat (n) begin
            fbuf.push_back(($urandom_range(0, 7) == 0) ? 8'hAA : 8'($urandom));
        end
    endfunction

    function automatic void put_word(input logic [15:0] w);
        fbuf.push_back(w[15:8]);
        fbuf.push_back(w[7:0]);
    endfunction

    // Radiotap header of the given total length (at least the four fixed bytes).
    function automatic void put_radiotap(input logic [15:0] len);
        fbuf.push_back(8'($urandom));
        fbuf.push_back(8'($urandom));
        fbuf.push_back(len[7:0]);
        fbuf.push_back(len[15:8]);
        if (len > 4) begin
            put_fill(int'(len) - 4);
        end
    endfunction

    // 802.11 MAC part: frame control byte, then an LLC/SNAP header starting
    // snap_at bytes after it (none when negative), OUI, EtherType and a tail.
    function automatic void put_mac(input logic [7:0] fc, input int snap_at,
                                    input logic [15:0] et, input int tail);
        fbuf.push_back(fc);
        if (snap_at < 0) begin
            put_fill(40);
        end else begin
            put_fill(snap_at - 1);
            fbuf.push_back(lhel_pkg::SNAP_HDR[23:16]);
            fbuf.push_back(lhel_pkg::SNAP_HDR[15:8]);
            fbuf.push_back(lhel_pkg::SNAP_HDR[7:0]);
            put_fill(3);
            put_word(et);
        end
        put_fill(tail);
    endfunction

    function automatic void send_frame();
        lhel_pkg::t_item it;
        foreach (fbuf[i]) begin
            it.frame_byte = fbuf[i];
            it.frame_end  = (i == fbuf.size() - 1);
            pending_bytes.push_back(it);
            bytes_queued++;
        end
        fbuf.delete();
        frames_queued++;
    endfunction

    function automatic void eth_frame(input int hdr, input logic [15:0] et, input int tail);
        put_fill(hdr);
        put_word(et);
        put_fill(tail);
        send_frame();
    endfunction

    // One random frame for the given link type: mostly well formed, with a
    // share of non-data frames, missing SNAP headers and early ends.
    function automatic void rand_frame(input logic [lhel_pkg::LT_W-1:0] lt);
        int unsigned r;
        int unsigned pick;
        int          cut;
        int          snap;
        logic [15:0] et;
        logic [15:0] len;
        logic [3:0]  sub;
        logic [7:0]  fc;
        cut  = 0;
        snap = -1;
        pick = $urandom_range(0, 3);
        et = (pick == 0) ? lhel_pkg::ET_IPV4 : (pick == 1) ? lhel_pkg::ET_IPV6 :
             (pick == 2) ? lhel_pkg::ET_VLAN : 16'($urandom);
        r = $urandom_range(0, 99);
        if (lt == lhel_pkg::LT_ETHERNET || lt == lhel_pkg::LT_COOKED) begin
            put_fill((lt == lhel_pkg::LT_ETHERNET) ? 12 : 14);
            put_word(et);
            put_fill($urandom_range(0, 10));
            if (r >= 88) begin
                cut = $urandom_range(1, (lt == lhel_pkg::LT_ETHERNET) ? 13 : 15);
            end
        end else begin
            if (lt == lhel_pkg::LT_RADIOTAP) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    len = 16'($urandom_range(0, 3));
                end else if (pick < 14) begin
                    len = 16'($urandom_range(4, 300));
                end else begin
                    len = 16'($urandom_range(4, 24));
                end
                put_radiotap(len);
            end
            sub = 4'($urandom_range(0, 7));
            if (sub >= 4) begin
                sub = sub + 4'd4;
            end
            fc = (r < 80) ? {sub, 2'b10, 2'($urandom)} : 8'($urandom);
            if ($urandom_range(0, 99) < 85) begin
                snap = $urandom_range(24, 36);
            end
            put_mac(fc, snap, et, $urandom_range(0, 6));
            if (r >= 90) begin
                cut = $urandom_range(1, fbuf.size());
            end
        end
        if (cut != 0) begin
            while (fbuf.size() > cut) begin
                void'(fbuf.pop_back());
            end
        end
        send_frame();
    endfunction

    // ------------------------------------------------------------------------
    // Phase control. The link type is written only once every queued byte has
    // been taken and every result has come back, plus a short settling time.
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_link(input logic [lhel_pkg::LT_W-1:0] lt);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.link_type <= lt;
        do begin
            @(posedge clk);
        end while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_link = lt;
        link_writes[lt]++;
    endtask

    initial begin
        int          n;
        logic [1:0]  lt;

        cur_link = lhel_pkg::LT_ETHERNET;
        clear_frame_state();
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.link_type = '0;
        frame_if.valid = 1'b0;
        frame_if.frame_byte = '0;
        frame_if.frame_end = 1'b0;
        res_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Ethernet: each EtherType class, both extreme values, a frame that
        // stops after the first EtherType byte and single-byte frames.
        set_link(lhel_pkg::LT_ETHERNET);
        eth_frame(12, lhel_pkg::ET_IPV4, 6);
        eth_frame(12, lhel_pkg::ET_IPV6, 0);
        eth_frame(12, lhel_pkg::ET_VLAN, 4);
        eth_frame(12, 16'hFFFF, 2);
        eth_frame(12, 16'h0000, 1);
        put_fill(13);
        send_frame();
        fbuf.push_back(8'hFF);
        send_frame();
        fbuf.push_back(8'h00);
        send_frame();
        wait_drained();

        // Linux cooked capture, back to back: exact fit and one byte short.
        no_idle = 1'b1;
        set_link(lhel_pkg::LT_COOKED);
        eth_frame(14, lhel_pkg::ET_IPV4, 0);
        put_fill(15);
        send_frame();
        wait_drained();

        // Raw 802.11: data frames at both ends of the search window, the
        // refused frame classes, SNAP just outside the window, no SNAP at all
        // and frames that end before the search is decided.
        no_idle = 1'b0;
        set_link(lhel_pkg::LT_RAW_WLAN);
        put_mac(8'h08, 24, lhel_pkg::ET_IPV4, 3);
        send_frame();
        put_mac(8'hB8, 36, lhel_pkg::ET_VLAN, 0);
        send_frame();
        put_mac(8'h88, 30, lhel_pkg::ET_IPV6, 5);
        send_frame();
        put_mac(8'hD4, 24, lhel_pkg::ET_IPV4, 0);   // control
        send_frame();
        put_mac(8'h80, 24, lhel_pkg::ET_IPV4, 0);   // management
        send_frame();
        put_mac(8'h48, 24, lhel_pkg::ET_IPV4, 0);   // null data
        send_frame();
        put_mac(8'hC8, 24, lhel_pkg::ET_IPV4, 0);   // data subtype above the QoS range
        send_frame();
        put_mac(8'h0C, 24, lhel_pkg::ET_IPV4, 0);   // reserved frame type
        send_frame();
        put_mac(8'h08, -1, lhel_pkg::ET_IPV4, 0);
        send_frame();
        put_mac(8'h18, 23, lhel_pkg::ET_IPV4, 4);
        send_frame();
        put_mac(8'h28, 37, lhel_pkg::ET_IPV4, 0);
        send_frame();
        put_mac(8'h08, 30, lhel_pkg::ET_IPV4, 0);
        while (fbuf.size() > 29) begin
            void'(fbuf.pop_back());
        end
        send_frame();
        fbuf.push_back(8'h08);
        send_frame();
        wait_drained();

        // Radiotap: ordinary and minimum lengths, lengths too small to hold
        // the length field, and a frame that ends inside the header.
        set_link(lhel_pkg::LT_RADIOTAP);
        put_radiotap(16'd8);
        put_mac(8'h08, 24, lhel_pkg::ET_IPV4, 2);
        send_frame();
        put_radiotap(16'd2);
        put_mac(8'h08, 24, lhel_pkg::ET_IPV4, 0);
        send_frame();
        put_radiotap(16'd0);
        put_mac(8'h08, 24, lhel_pkg::ET_IPV4, 0);
        send_frame();
        put_radiotap(16'd4);
        put_mac(8'h38, 36, 16'h88CC, 0);
        send_frame();
        put_fill(3);
        send_frame();
        wait_drained();

        // Random part: short phases, each with its own link type and a few
        // frames; some phases run without any idling on either side.
        while (bytes_queued < 860) begin
            lt = 2'($urandom_range(0, 3));
            no_idle = ($urandom_range(0, 3) == 0);
            set_link(lt);
            n = $urandom_range(3, 8);
            repeat (n) begin
                rand_frame(lt);
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d frames in %0d bytes.", frames_queued, bytes_accepted);
        $display("Link type writes: ethernet %0d, cooked %0d, raw 802.11 %0d, radiotap %0d.",
                 link_writes[0], link_writes[1], link_writes[2], link_writes[3]);
        $display("Results by status: ip %0d, vlan %0d, other %0d, not found %0d, too short %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run under the longest stalls.
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lhel_pkg.sv
rtl/core/lhel_if.sv
rtl/core/lhel_in_reg.sv
rtl/core/lhel_parser.sv
rtl/core/lhel_out_reg.sv
rtl/core/link_header_ethertype_locator.sv
rtl/core/lhel_checker.sv
bench/tb_top.sv
